// ===== sv/sorted_x_nearest_neighbour_search_top_defines.svh =====
// Assertion macros for the sorted-x nearest-neighbour search block.
// Included by the port checker; expects clk_i and rst_ni in scope.
`ifndef SORTED_X_NEAREST_NEIGHBOUR_SEARCH_TOP_DEFINES_SVH
`define SORTED_X_NEAREST_NEIGHBOUR_SEARCH_TOP_DEFINES_SVH

// same-cycle implication
`define SXNN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SXNN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sxnn_pkg.sv =====
// Shared types and constants for the sorted-x nearest-neighbour search block.
// No dependencies; used by every module of the block.
package sxnn_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int COORD_BITS  = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int RAD_W       = 16;
  localparam int OP_W        = (COORD_BITS > RAD_W) ? COORD_BITS : RAD_W;
  localparam int SQ_W        = 2 * OP_W;
  localparam int DIST_W      = SQ_W + 1;
  localparam int OUT_DIST_W  = 2 * COORD_BITS + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE = 1'b1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic MODE_PREY   = 1'b0;
  localparam logic MODE_DANGER = 1'b1;

  typedef struct packed {
    logic                         action;
    logic [IDX_W-1:0]             entry_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic                         is_deleted;
    logic                         is_hunter;
    logic                         is_alive;
    logic [RAD_W-1:0]             detect_radius;
  } in_beat_t;

  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      found_index;
    logic [OUT_DIST_W-1:0] found_dist_sq;
  } out_beat_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         del;
    logic                         hunter;
    logic                         alive;
  } entry_t;

endpackage

// ===== sv/sorted_x_nearest_neighbour_search_top.sv =====
// Top level of the sorted-x nearest-neighbour search: entry memory, sweep sequencer,
// result register. Depends on sxnn_pkg and sxnn_sq_unit.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   sxnn_pkg::in_beat_t
//   out      output     out_valid_o / out_stall_i sxnn_pkg::out_beat_t
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// A write beat is stored when accepted. A query squares the radius and sets up in S_INIT,
// visits each table entry in S_ADDR, S_SQX, S_SQY, S_ACC (no S_ACC for one cut off by the
// dx*dx test), loads the result in S_DONE. One squarer and one read port force this order.
// Reset clears the config registers and control; the entry memory is not cleared.
// A stalled result holds in the output register; input is stalled only while a
// query runs or its result waits for the output register to free up.
module sorted_x_nearest_neighbour_search_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sxnn_pkg::in_beat_t                  in_beat_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sxnn_pkg::out_beat_t                 out_beat_o,
  input  logic                                cfg_we_i,
  input  logic [sxnn_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sxnn_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int IDX_W  = sxnn_pkg::IDX_W;
  localparam int CNT_W  = sxnn_pkg::CNT_W;
  localparam int CB     = sxnn_pkg::COORD_BITS;
  localparam int OP_W   = sxnn_pkg::OP_W;
  localparam int SQ_W   = sxnn_pkg::SQ_W;
  localparam int DIST_W = sxnn_pkg::DIST_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_SQX  = 3'd3;
  localparam logic [2:0] S_SQY  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(sxnn_pkg::MAX_ENTRIES);

  sxnn_pkg::entry_t entry_mem [sxnn_pkg::MAX_ENTRIES];
  sxnn_pkg::entry_t ent_q;

  logic [CNT_W-1:0]     entry_count_q;
  logic                 search_mode_q;

  logic [2:0]           state_q, state_d;
  logic                 side_q, side_d;
  logic                 have_q, have_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [CB-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [CNT_W-1:0]     j_q, j_d;
  logic [SQ_W-1:0]      r2_q, r2_d;
  logic [SQ_W-1:0]      dx2_q, dx2_d;
  logic [DIST_W-1:0]    best_q, best_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  sxnn_pkg::out_beat_t  out_q, out_d;

  logic                 in_acc;
  logic                 out_acc;
  logic [OP_W-1:0]      mul_op;
  logic [SQ_W-1:0]      sq;
  logic [CB:0]          dx_s, dy_s, dx_n, dy_n;
  logic [OP_W-1:0]      dx_abs, dy_abs;
  logic                 qual;
  logic [CNT_W-1:0]     start_j;
  logic [CNT_W-1:0]     right_first;
  logic                 right_ok;
  logic                 prune;
  logic [DIST_W-1:0]    d2;
  logic                 take;
  logic                 adv;
  logic                 stop;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      search_mode_q <= sxnn_pkg::MODE_PREY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sxnn_pkg::CFG_ENTRY_COUNT: entry_count_q <= cfg_wdata_i;
        sxnn_pkg::CFG_SEARCH_MODE: search_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_beat_i.action == sxnn_pkg::ACT_WRITE) begin
      entry_mem[in_beat_i.entry_index] <= '{x:      in_beat_i.pos_x,
                                            y:      in_beat_i.pos_y,
                                            del:    in_beat_i.is_deleted,
                                            hunter: in_beat_i.is_hunter,
                                            alive:  in_beat_i.is_alive};
    end
    ent_q <= entry_mem[j_q[IDX_W-1:0]];
  end

  assign dx_s = {qx_q[CB-1], qx_q} - {ent_q.x[CB-1], ent_q.x};
  assign dy_s = {qy_q[CB-1], qy_q} - {ent_q.y[CB-1], ent_q.y};
  assign dx_n = -dx_s;
  assign dy_n = -dy_s;
  assign dx_abs = dx_s[CB] ? OP_W'(dx_n[CB-1:0]) : OP_W'(dx_s[CB-1:0]);
  assign dy_abs = dy_s[CB] ? OP_W'(dy_n[CB-1:0]) : OP_W'(dy_s[CB-1:0]);

  always_comb begin
    case (state_q)
      S_IDLE:  mul_op = OP_W'(in_beat_i.detect_radius);
      S_SQX:   mul_op = dx_abs;
      S_SQY:   mul_op = dy_abs;
      default: mul_op = '0;
    endcase
  end

  sxnn_sq_unit u_sq (
    .clk_i (clk_i),
    .op_i  (mul_op),
    .sq_o  (sq)
  );

  assign qual = (search_mode_q == sxnn_pkg::MODE_DANGER) ?
                (ent_q.alive && ent_q.hunter) :
                (!ent_q.del && (!ent_q.hunter || !ent_q.alive));

  assign start_j     = (CNT_W'(idx_q) < n_q) ? CNT_W'(idx_q) : n_q;
  assign right_first = CNT_W'(idx_q) + CNT_W'(1);
  assign right_ok    = right_first < n_q;
  assign prune       = have_q && (DIST_W'(sq) > best_q);
  assign d2          = DIST_W'(dx2_q) + DIST_W'(sq);
  assign take        = qual && (!have_q || d2 < best_q) && (d2 <= DIST_W'(r2_q));

  always_comb begin
    state_d     = state_q;
    side_d      = side_q;
    have_d      = have_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    idx_d       = idx_q;
    n_d         = n_q;
    j_d         = j_q;
    r2_d        = r2_q;
    dx2_d       = dx2_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_acc;
    adv         = 1'b0;
    stop        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc && in_beat_i.action == sxnn_pkg::ACT_QUERY) begin
          qx_d       = in_beat_i.pos_x;
          qy_d       = in_beat_i.pos_y;
          idx_d      = in_beat_i.entry_index;
          n_d        = (entry_count_q > MAX_CNT) ? MAX_CNT : entry_count_q;
          have_d     = 1'b0;
          best_d     = '0;
          best_idx_d = '0;
          state_d    = S_INIT;
        end
      end
      S_INIT: begin
        r2_d = sq;
        if (n_q < CNT_W'(2)) begin
          state_d = S_DONE;
        end else if (start_j != '0) begin
          j_d     = start_j - CNT_W'(1);
          side_d  = SIDE_LEFT;
          state_d = S_ADDR;
        end else if (right_ok) begin
          j_d     = right_first;
          side_d  = SIDE_RIGHT;
          state_d = S_ADDR;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ADDR: state_d = S_SQX;
      S_SQX:  state_d = S_SQY;
      S_SQY: begin
        if (prune) begin
          stop = 1'b1;
        end else begin
          dx2_d   = sq;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (take) begin
          have_d     = 1'b1;
          best_d     = d2;
          best_idx_d = j_q[IDX_W-1:0];
        end
        adv = 1'b1;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.found         = have_q;
          out_d.found_index   = have_q ? best_idx_q : '0;
          out_d.found_dist_sq = have_q ? best_q : '0;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // advance along the current side, or switch sides, or finish
    if (adv || stop) begin
      if (side_q == SIDE_LEFT) begin
        if (adv && j_q != '0) begin
          j_d     = j_q - CNT_W'(1);
          state_d = S_ADDR;
        end else if (right_ok) begin
          j_d     = right_first;
          side_d  = SIDE_RIGHT;
          state_d = S_ADDR;
        end else begin
          state_d = S_DONE;
        end
      end else begin
        if (adv && (j_q + CNT_W'(1)) < n_q) begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_ADDR;
        end else begin
          state_d = S_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      side_q      <= SIDE_LEFT;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q       <= qx_d;
    qy_q       <= qy_d;
    idx_q      <= idx_d;
    r2_q       <= r2_d;
    dx2_q      <= dx2_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

// ===== sv/sxnn_sq_unit.sv =====
// Shared squaring unit: registered op*op, one result per cycle.
// Depends on sxnn_pkg for operand and result widths.
module sxnn_sq_unit (
  input  logic                          clk_i,
  input  logic [sxnn_pkg::OP_W-1:0]     op_i,
  output logic [sxnn_pkg::SQ_W-1:0]     sq_o
);

  logic [sxnn_pkg::SQ_W-1:0] sq_q;

  always_ff @(posedge clk_i) begin
    sq_q <= sxnn_pkg::SQ_W'(op_i) * sxnn_pkg::SQ_W'(op_i);
  end

  assign sq_o = sq_q;

endmodule

// ===== sv/sxnn_checker.sv =====
// Port-level checker for the sorted-x nearest-neighbour search top, bound to it below.
// Depends on sxnn_pkg and the assertion macros header.
`include "sorted_x_nearest_neighbour_search_top_defines.svh"

module sxnn_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input sxnn_pkg::in_beat_t  in_beat_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sxnn_pkg::out_beat_t out_beat_o
);

  logic wr_beat;
  logic qry_beat;
  logic out_held;
  logic empty_beat;
  logic empty_zero;

  assign wr_beat  = in_valid_i && !in_stall_o && in_beat_i.action == sxnn_pkg::ACT_WRITE;
  assign qry_beat = in_valid_i && !in_stall_o && in_beat_i.action == sxnn_pkg::ACT_QUERY;
  assign out_held   = out_valid_o && out_stall_i;
  assign empty_beat = out_valid_o && !out_beat_o.found;
  assign empty_zero = out_beat_o.found_index == '0 && out_beat_o.found_dist_sq == '0;

  `SXNN_ASSERT_NEXT(a_out_hold, out_held, out_valid_o, "result beat dropped while stalled")
  `SXNN_ASSERT_SAME(a_none_zero, empty_beat, empty_zero, "empty result carries nonzero fields")
  `SXNN_ASSERT_NEXT(a_query_busy, qry_beat, in_stall_o, "query beat not followed by stall")
  `SXNN_ASSERT_NEXT(a_write_free, wr_beat, !in_stall_o, "write beat left input stalled")

endmodule

bind sorted_x_nearest_neighbour_search_top sxnn_checker u_sxnn_checker (.*);
